[hdl/trh_pkg.sv]
// ----------------------------------------------------------------------------
// trh_pkg
// Shared constants, codes, pointer helpers and the control/status bundles
// of the task ring with half spill.
// ----------------------------------------------------------------------------
package trh_pkg;

  // Ring geometry and task width
  localparam int RING_DEPTH  = 32;
  localparam int TASK_BITS   = 64;
  localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PTR_W       = $clog2(2 * RING_DEPTH);
  localparam int PTR_MOD     = 2 * RING_DEPTH;

  // Port field widths
  localparam int OP_W        = 2;
  localparam int ST_W        = 3;
  localparam int TASK_PORT_W = 64;
  localparam int DATA_W      = 72;
  localparam int OUT_PAD_W   = DATA_W - ST_W - TASK_PORT_W;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TASK_BITS-1:0] task_t;
  typedef logic [OP_W-1:0]      op_code_t;
  typedef logic [ST_W-1:0]      status_t;

  localparam ptr_t PTR_ONE  = PTR_W'(1);
  localparam ptr_t PTR_HALF = PTR_W'(RING_DEPTH / 2);

  // Operation codes
  localparam op_code_t OP_PUSH   = 2'd0;
  localparam op_code_t OP_POP    = 2'd1;
  localparam op_code_t OP_REFILL = 2'd2;

  // Result status codes
  localparam status_t STS_PUSHED       = 3'd0;
  localparam status_t STS_PUSHED_SPILL = 3'd1;
  localparam status_t STS_POPPED       = 3'd2;
  localparam status_t STS_POP_EMPTY    = 3'd3;
  localparam status_t STS_SPILLED      = 3'd4;
  localparam status_t STS_REFILL_OK    = 3'd5;
  localparam status_t STS_REFILL_FULL  = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_SPILL_RD,
    S_SPILL_LD,
    S_SPILL_WAIT,
    S_SPILL_PUSH,
    S_OUT_WAIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    cap;          // latch the incoming transaction
    logic    mem_wr;       // store the task at tail, advance tail
    logic    rd_head;      // read the slot at head
    logic    rd_spill;     // read the slot at the spill pointer, advance it
    logic    sp_init;      // spill pointer to head plus half
    logic    tail_rewind;  // tail back to head plus half
    logic    head_inc;     // advance head
    logic    out_load;     // load the result register
    logic    out_from_mem; // result task from read data, else zero
    logic    out_last;
    status_t out_status;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_code_t op;
    logic     full;
    logic     empty;
    logic     spill_end;
    logic     out_taken;
  } dp_sts_t;

  // Add modulo twice the depth
  function automatic ptr_t ptr_add(ptr_t p, ptr_t n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= (PTR_W+1)'(PTR_MOD)) begin
      s = s - (PTR_W+1)'(PTR_MOD);
    end
    return s[PTR_W-1:0];
  endfunction

  // Slot index of a pointer
  function automatic idx_t ptr_slot(ptr_t p);
    ptr_t s;
    if (p >= PTR_W'(RING_DEPTH)) begin
      s = p - PTR_W'(RING_DEPTH);
    end else begin
      s = p;
    end
    return s[IDX_W-1:0];
  endfunction

  // Number of tasks held between head and tail
  function automatic ptr_t ring_count(ptr_t t, ptr_t h);
    logic [PTR_W:0] c;
    if (t >= h) begin
      c = {1'b0, t} - {1'b0, h};
    end else begin
      c = {1'b0, t} + (PTR_W+1)'(PTR_MOD) - {1'b0, h};
    end
    return c[PTR_W-1:0];
  endfunction

endpackage

[hdl/trh_dpath.sv]
// ----------------------------------------------------------------------------
// trh_dpath
// Ring storage, head/tail/spill pointers, captured transaction and the
// result register.
// ----------------------------------------------------------------------------
module trh_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  trh_pkg::ctrl_cmd_t              cmd,
  output trh_pkg::dp_sts_t                sts,
  input  trh_pkg::op_code_t               in_op,
  input  trh_pkg::task_t                  in_task,
  input  logic                            out_ready,
  output logic                            out_valid,
  output trh_pkg::status_t                out_status,
  output logic [trh_pkg::TASK_PORT_W-1:0] out_task,
  output logic                            out_last
);

  trh_pkg::task_t task_mem [trh_pkg::RING_DEPTH];

  trh_pkg::ptr_t     head_r, head_nxt;
  trh_pkg::ptr_t     tail_r, tail_nxt;
  trh_pkg::ptr_t     sp_r, sp_nxt;
  trh_pkg::op_code_t op_r;
  trh_pkg::task_t    task_r;
  trh_pkg::task_t    rdata_r;
  trh_pkg::idx_t     rd_addr;
  trh_pkg::ptr_t     count;
  logic              full;

  logic                            out_valid_r, out_valid_nxt;
  trh_pkg::status_t                out_status_r;
  logic [trh_pkg::TASK_PORT_W-1:0] out_task_r;
  logic                            out_last_r;

  assign count = trh_pkg::ring_count(tail_r, head_r);
  assign full  = (count >= trh_pkg::PTR_W'(trh_pkg::RING_DEPTH));

  assign sts.op        = op_r;
  assign sts.full      = full;
  assign sts.empty     = (tail_r == head_r);
  assign sts.spill_end = (sp_r == tail_r);
  assign sts.out_taken = out_valid_r & out_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    sp_nxt   = sp_r;
    if (cmd.head_inc) begin
      head_nxt = trh_pkg::ptr_add(head_r, trh_pkg::PTR_ONE);
    end
    if (cmd.tail_rewind) begin
      tail_nxt = trh_pkg::ptr_add(head_r, trh_pkg::PTR_HALF);
    end else if (cmd.mem_wr) begin
      tail_nxt = trh_pkg::ptr_add(tail_r, trh_pkg::PTR_ONE);
    end
    if (cmd.sp_init) begin
      sp_nxt = trh_pkg::ptr_add(head_r, trh_pkg::PTR_HALF);
    end else if (cmd.rd_spill) begin
      sp_nxt = trh_pkg::ptr_add(sp_r, trh_pkg::PTR_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r <= sp_nxt;
    if (cmd.cap) begin
      op_r   <= in_op;
      task_r <= in_task;
    end
  end

  // Ring memory: one write port at tail, one registered read port
  assign rd_addr = cmd.rd_head ? trh_pkg::ptr_slot(head_r) : trh_pkg::ptr_slot(sp_r);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      task_mem[trh_pkg::ptr_slot(tail_r)] <= task_r;
    end
    if (cmd.rd_head || cmd.rd_spill) begin
      rdata_r <= task_mem[rd_addr];
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_task_r   <= cmd.out_from_mem ? trh_pkg::TASK_PORT_W'(rdata_r) : '0;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_task   = out_task_r;
  assign out_last   = out_last_r;

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |-> !full)
    else $error("ring write while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.head_inc |-> (tail_r != head_r))
    else $error("head advanced on empty ring");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("result register loaded while still holding a result");

  a_rewind_to_half: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tail_rewind |=> (trh_pkg::ring_count(tail_r, head_r) == trh_pkg::PTR_HALF))
    else $error("tail rewind left a wrong task count");

endmodule

[hdl/trh_ctrl.sv]
// ----------------------------------------------------------------------------
// trh_ctrl
// Sequencer for push, pop, refill and the half spill run.
// ----------------------------------------------------------------------------
module trh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  trh_pkg::dp_sts_t   sts,
  output trh_pkg::ctrl_cmd_t cmd
);

  trh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trh_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = trh_pkg::S_EXEC;
        end
      end
      trh_pkg::S_EXEC: begin
        case (sts.op)
          trh_pkg::OP_PUSH: begin
            state_nxt = sts.full ? trh_pkg::S_SPILL_RD : trh_pkg::S_OUT_WAIT;
          end
          trh_pkg::OP_POP: begin
            state_nxt = sts.empty ? trh_pkg::S_OUT_WAIT : trh_pkg::S_POP_RD;
          end
          trh_pkg::OP_REFILL: begin
            state_nxt = trh_pkg::S_OUT_WAIT;
          end
          default: begin
            state_nxt = trh_pkg::S_IDLE;
          end
        endcase
      end
      trh_pkg::S_POP_RD: begin
        state_nxt = trh_pkg::S_OUT_WAIT;
      end
      trh_pkg::S_SPILL_RD: begin
        state_nxt = sts.spill_end ? trh_pkg::S_SPILL_PUSH : trh_pkg::S_SPILL_LD;
      end
      trh_pkg::S_SPILL_LD: begin
        state_nxt = trh_pkg::S_SPILL_WAIT;
      end
      trh_pkg::S_SPILL_WAIT: begin
        if (sts.out_taken) begin
          state_nxt = trh_pkg::S_SPILL_RD;
        end
      end
      trh_pkg::S_SPILL_PUSH: begin
        state_nxt = trh_pkg::S_OUT_WAIT;
      end
      trh_pkg::S_OUT_WAIT: begin
        if (sts.out_taken) begin
          state_nxt = trh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = trh_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      trh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      trh_pkg::S_EXEC: begin
        case (sts.op)
          trh_pkg::OP_PUSH: begin
            if (sts.full) begin
              cmd.sp_init = 1'b1;
            end else begin
              cmd.mem_wr     = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = trh_pkg::STS_PUSHED;
            end
          end
          trh_pkg::OP_POP: begin
            if (sts.empty) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = trh_pkg::STS_POP_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
            end
          end
          trh_pkg::OP_REFILL: begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            if (sts.full) begin
              cmd.out_status = trh_pkg::STS_REFILL_FULL;
            end else begin
              cmd.mem_wr     = 1'b1;
              cmd.out_status = trh_pkg::STS_REFILL_OK;
            end
          end
          default: begin
            // spare op code: drop the transaction
          end
        endcase
      end
      trh_pkg::S_POP_RD: begin
        cmd.head_inc     = 1'b1;
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_last     = 1'b1;
        cmd.out_status   = trh_pkg::STS_POPPED;
      end
      trh_pkg::S_SPILL_RD: begin
        if (sts.spill_end) begin
          cmd.tail_rewind = 1'b1;
        end else begin
          cmd.rd_spill = 1'b1;
        end
      end
      trh_pkg::S_SPILL_LD: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_mem = 1'b1;
        cmd.out_status   = trh_pkg::STS_SPILLED;
      end
      trh_pkg::S_SPILL_WAIT: begin
      end
      trh_pkg::S_SPILL_PUSH: begin
        cmd.mem_wr     = 1'b1;
        cmd.out_load   = 1'b1;
        cmd.out_last   = 1'b1;
        cmd.out_status = trh_pkg::STS_PUSHED_SPILL;
      end
      trh_pkg::S_OUT_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  a_idle_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trh_pkg::S_IDLE) |-> !sts.out_taken)
    else $error("result still pending while idle");

  a_spill_only_from_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sp_init |-> sts.full)
    else $error("spill started on a ring that is not full");

  a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == trh_pkg::S_EXEC) |-> $past(cmd.cap))
    else $error("execute without a captured transaction");

endmodule

[hdl/task_ring_with_half_spill_unit.sv]
// ----------------------------------------------------------------------------
// task_ring_with_half_spill_unit
// Local task ring with push, pop, refill and half spill on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   One input stream carries transactions {task_in, op}; one result stream
//   carries {task_out, status} with tlast marking the final result of each
//   transaction. Every op gives exactly one result except a push into a full
//   ring, which first gives RING_DEPTH - RING_DEPTH/2 spilled tasks (oldest
//   first, tlast low), then the push result with tlast high. Op code 3 is
//   dropped with no result.
//   Timing: the unit handles one transaction at a time. After acceptance a
//   push, refill or empty pop loads its result in the execute state, a pop
//   in the state after it (registered ring read). Each spilled task is read,
//   loaded into the result register, then held on the result bus until the
//   receiver takes it, so any receiver stall lengthens the spill. The next
//   transaction is accepted the cycle after the final result is taken, so
//   no new transaction is taken while a result of the last one is pending.
//   Reset empties the ring (head and tail to zero) and clears the result
//   valid flag. When the receiver stalls, the result register holds its
//   transaction and no new input is taken.
// ----------------------------------------------------------------------------
module task_ring_with_half_spill_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [trh_pkg::DATA_W-1:0] in_tdata,   // [1:0] op, [65:2] task_in
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [trh_pkg::DATA_W-1:0] out_tdata,  // [2:0] status, [66:3] task_out
  output logic                       out_tlast
);

  trh_pkg::ctrl_cmd_t              cmd;
  trh_pkg::dp_sts_t                sts;
  trh_pkg::op_code_t               in_op;
  trh_pkg::task_t                  in_task;
  trh_pkg::status_t                out_status;
  logic [trh_pkg::TASK_PORT_W-1:0] out_task;

  assign in_op   = in_tdata[trh_pkg::OP_W-1:0];
  assign in_task = in_tdata[trh_pkg::OP_W +: trh_pkg::TASK_BITS];

  trh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trh_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_op),
    .in_task    (in_task),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_task   (out_task),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{trh_pkg::OUT_PAD_W{1'b0}}, out_task, out_status};

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop, refill and unused-op transactions into the task ring.
// An in-bench ring tracks head, tail and slot contents and predicts every
// result, including the half spill when a push hits a full ring. Both
// stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module testbench;

  localparam trh_pkg::op_code_t OP_UNUSED  = 2'd3;
  localparam int                WORK_ITEMS = 420;
  localparam int                CYCLE_CAP  = 400000;
  localparam int                DRAIN_WAIT = 2 * trh_pkg::RING_DEPTH + 8;

  typedef struct {
    trh_pkg::op_code_t op;
    logic [63:0]       word;
  } ring_req_t;

  typedef struct {
    trh_pkg::status_t  status;
    logic [63:0]       word;
    logic              last;
  } ring_rsp_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [trh_pkg::DATA_W-1:0] in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [trh_pkg::DATA_W-1:0] out_tdata;
  logic                       out_tlast;

  ring_req_t           pending_reqs[$];
  ring_rsp_t           owed_results[$];
  ring_req_t           on_bus;
  bit                  bus_loaded;
  int                  send_gap;
  int                  taken_cnt;
  int                  stall_left;
  int                  result_cnt;
  int                  mismatch_cnt;
  int                  cycle_cnt;
  trh_pkg::status_t    seen_status;
  logic [63:0]         seen_word;
  ring_rsp_t           want;

  // Tracked ring state
  trh_pkg::task_t      slots[trh_pkg::RING_DEPTH];
  trh_pkg::ptr_t       head_p;
  trh_pkg::ptr_t       tail_p;

  task_ring_with_half_spill_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [1:0] op, [65:2] task_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [2:0] status, [66:3] task_out
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic trh_pkg::ptr_t bump(trh_pkg::ptr_t p, int n);
    return trh_pkg::ptr_t'((int'(p) + n) % trh_pkg::PTR_MOD);
  endfunction

  function automatic void owe(trh_pkg::status_t st, logic [63:0] word, logic last);
    ring_rsp_t r;
    r.status = st;
    r.word   = word;
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // Apply one accepted transaction to the tracked ring and queue its results
  function automatic void advance_ring(ring_req_t r);
    int             held;
    trh_pkg::ptr_t  p;
    trh_pkg::task_t t;
    held = (int'(tail_p) + trh_pkg::PTR_MOD - int'(head_p)) % trh_pkg::PTR_MOD;
    t    = trh_pkg::task_t'(r.word);
    case (r.op)
      trh_pkg::OP_PUSH: begin
        if (held >= trh_pkg::RING_DEPTH) begin
          // spill the newer half, oldest first, then pull tail back
          p = bump(head_p, trh_pkg::RING_DEPTH / 2);
          while (p != tail_p) begin
            owe(trh_pkg::STS_SPILLED,
                trh_pkg::TASK_PORT_W'(slots[int'(p) % trh_pkg::RING_DEPTH]), 1'b0);
            p = bump(p, 1);
          end
          tail_p = bump(head_p, trh_pkg::RING_DEPTH / 2);
          slots[int'(tail_p) % trh_pkg::RING_DEPTH] = t;
          tail_p = bump(tail_p, 1);
          owe(trh_pkg::STS_PUSHED_SPILL, '0, 1'b1);
        end else begin
          slots[int'(tail_p) % trh_pkg::RING_DEPTH] = t;
          tail_p = bump(tail_p, 1);
          owe(trh_pkg::STS_PUSHED, '0, 1'b1);
        end
      end
      trh_pkg::OP_POP: begin
        if (held == 0) begin
          owe(trh_pkg::STS_POP_EMPTY, '0, 1'b1);
        end else begin
          owe(trh_pkg::STS_POPPED,
              trh_pkg::TASK_PORT_W'(slots[int'(head_p) % trh_pkg::RING_DEPTH]), 1'b1);
          head_p = bump(head_p, 1);
        end
      end
      trh_pkg::OP_REFILL: begin
        if (held >= trh_pkg::RING_DEPTH) begin
          owe(trh_pkg::STS_REFILL_FULL, '0, 1'b1);
        end else begin
          slots[int'(tail_p) % trh_pkg::RING_DEPTH] = t;
          tail_p = bump(tail_p, 1);
          owe(trh_pkg::STS_REFILL_OK, '0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [63:0] pick_task();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_req(trh_pkg::op_code_t op, logic [63:0] word);
    ring_req_t r;
    r.op   = op;
    r.word = word;
    pending_reqs.push_back(r);
  endfunction

  // Input driver: one transaction on the bus at a time, random gap before each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      bus_loaded = 1'b0;
      send_gap   = $urandom_range(0, 10);
      taken_cnt  = 0;
      head_p     = '0;
      tail_p     = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_ring(on_bus);
        bus_loaded = 1'b0;
        taken_cnt++;
        // every third stretch of 25 transactions runs without gaps
        send_gap = ((taken_cnt / 25) % 3 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (!bus_loaded) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          on_bus     = pending_reqs.pop_front();
          bus_loaded = 1'b1;
        end
      end
      in_tvalid <= bus_loaded;
      if (bus_loaded) begin
        in_tdata <= {{(trh_pkg::DATA_W - trh_pkg::OP_W - trh_pkg::TASK_PORT_W){1'b0}},
                     on_bus.word, on_bus.op};
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stall_left   = $urandom_range(0, 10);
      result_cnt   = 0;
      mismatch_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_status = out_tdata[trh_pkg::ST_W-1:0];
        seen_word   = out_tdata[trh_pkg::ST_W +: trh_pkg::TASK_PORT_W];
        result_cnt++;
        if (owed_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected result: status %0d task %h last %b",
                     seen_status, seen_word, out_tlast);
          end
        end else begin
          want = owed_results.pop_front();
          if (seen_status !== want.status || seen_word !== want.word ||
              out_tlast !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: exp st %0d task %h last %b, got st %0d task %h last %b",
                       want.status, want.word, want.last,
                       seen_status, seen_word, out_tlast);
            end
          end
        end
        stall_left = ((result_cnt / 40) % 3 == 2) ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int                work_cnt;
    int                mode;
    int                seg;
    int                roll;
    trh_pkg::op_code_t op;

    // Directed: empty pop, extreme words, every op, dropped op, drain past empty
    queue_req(trh_pkg::OP_POP, '0);
    queue_req(trh_pkg::OP_PUSH, '0);
    queue_req(trh_pkg::OP_PUSH, '1);
    queue_req(trh_pkg::OP_REFILL, 64'h5555_5555_5555_5555);
    queue_req(trh_pkg::OP_REFILL, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(OP_UNUSED, '1);
    queue_req(trh_pkg::OP_POP, '1);
    queue_req(trh_pkg::OP_POP, '0);
    queue_req(trh_pkg::OP_POP, '0);
    queue_req(trh_pkg::OP_POP, '0);
    queue_req(trh_pkg::OP_POP, '0);
    queue_req(trh_pkg::OP_PUSH, 64'h8000_0000_0000_0001);
    queue_req(trh_pkg::OP_POP, '0);
    work_cnt = 12;

    // Random: fill bursts drive the ring to full (spills, refill rejects),
    // drain bursts walk it back to empty, mixed and noisy stretches between
    while (work_cnt < WORK_ITEMS) begin
      mode = $urandom_range(0, 9);
      seg  = $urandom_range(20, 50);
      if (mode < 4) seg = $urandom_range(40, 70);
      repeat (seg) begin
        roll = $urandom_range(0, 99);
        if (mode < 4) begin
          op = (roll < 50) ? trh_pkg::OP_PUSH :
               (roll < 92) ? trh_pkg::OP_REFILL : trh_pkg::OP_POP;
        end else if (mode < 7) begin
          op = (roll < 80) ? trh_pkg::OP_POP :
               (roll < 90) ? trh_pkg::OP_PUSH : trh_pkg::OP_REFILL;
        end else if (mode < 9) begin
          op = (roll < 40) ? trh_pkg::OP_PUSH : (roll < 70) ? trh_pkg::OP_POP :
               (roll < 97) ? trh_pkg::OP_REFILL : OP_UNUSED;
        end else begin
          op = trh_pkg::op_code_t'($urandom_range(0, 3));
        end
        queue_req(op, pick_task());
        if (op != OP_UNUSED) work_cnt++;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (pending_reqs.size() != 0 || in_tvalid || owed_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
